FILE: design/sbd_pkg.sv
`default_nettype none

package sbd_pkg;

  // Frame and table sizes.
  localparam int MAX_LENGTH = 4096;
  localparam int TW_DEPTH   = 1024;

  // Field and state widths.
  localparam int SMP_W      = 16;
  localparam int ACC_W      = 48;
  localparam int LEN_W      = $clog2(MAX_LENGTH) + 1;
  localparam int CNT_W      = $clog2(MAX_LENGTH);
  localparam int BIN_W      = 12;
  localparam int PH_W       = $clog2(TW_DEPTH);
  localparam int PROD_W     = 2 * SMP_W;
  localparam int DIV_W      = BIN_W + PH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;
  localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = LEN_W'(1024);

  // Fixed-point constants used to build the twiddle table.
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH,
    REG_BIN_INDEX,
    REG_REAL_MODE
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } ctrl_state_e;

  typedef struct packed {
    logic div_start;
    logic in_ready;
    logic mul_en;
    logic acc_en;
  } sbd_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic div_busy;
    logic cfg_hit;
    logic acc_stall;
  } sbd_sts_t;

  typedef logic [PROD_W-1:0] tw_rom_t [TW_DEPTH];

  // Next series term before the division by the two new factorial factors.
  function automatic longint tw_next(longint term, longint x2);
    return -((term * x2) / Q30_ONE);
  endfunction

  // Taylor series for sin or cos of x in Q30 radians, x within [0, pi/4].
  // The divisors are k*(k+1) for k = 2, 4, ... (sin) or k = 1, 3, ... (cos).
  function automatic longint tw_series(longint x, bit want_sin);
    longint x2;
    longint term;
    longint sum;
    x2 = (x * x) / Q30_ONE;
    if (want_sin) begin
      term = x;
      sum  = term;
      term = tw_next(term, x2) / 64'sd6;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd20;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd42;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd72;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd110;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd156;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd210;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd272;
      sum  = sum + term;
    end else begin
      term = Q30_ONE;
      sum  = term;
      term = tw_next(term, x2) / 64'sd2;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd12;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd30;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd56;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd90;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd132;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd182;
      sum  = sum + term;
      term = tw_next(term, x2) / 64'sd240;
      sum  = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    return sum;
  endfunction

  function automatic logic signed [SMP_W-1:0] tw_to_q15(longint v);
    longint r;
    r = (v * 64'sd32767 + (Q30_ONE / 2)) / Q30_ONE;
    return SMP_W'(r);
  endfunction

  // One table entry: cos in the upper half, -sin in the lower half.
  function automatic logic [PROD_W-1:0] tw_entry(longint n);
    longint four_n;
    longint quad;
    longint m;
    longint k;
    longint ang;
    bit swap;
    logic signed [SMP_W-1:0] c;
    logic signed [SMP_W-1:0] s;
    logic signed [SMP_W-1:0] cc;
    logic signed [SMP_W-1:0] ss;
    logic signed [SMP_W-1:0] tmp;
    four_n = 64'sd4 * n;
    quad   = four_n / TW_DEPTH;
    m      = four_n - quad * TW_DEPTH;
    swap   = (64'sd2 * m > TW_DEPTH);
    k      = swap ? (TW_DEPTH - m) : m;
    ang    = (HALF_PI_Q30 * k + TW_DEPTH / 2) / TW_DEPTH;
    c      = tw_to_q15(tw_series(ang, 1'b0));
    s      = tw_to_q15(tw_series(ang, 1'b1));
    if (swap) begin
      tmp = c;
      c   = s;
      s   = tmp;
    end
    case (quad % 4)
      64'sd0: begin
        cc = c;
        ss = s;
      end
      64'sd1: begin
        cc = -s;
        ss = c;
      end
      64'sd2: begin
        cc = -c;
        ss = -s;
      end
      default: begin
        cc = s;
        ss = -c;
      end
    endcase
    return {cc, -ss};
  endfunction

  function automatic tw_rom_t tw_build();
    tw_rom_t rom;
    for (int n = 0; n < TW_DEPTH; n++) begin
      rom[n] = tw_entry(longint'(n));
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = tw_build();

endpackage

`default_nettype wire

FILE: design/sbd_if.sv
`default_nettype none

interface sbd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbd_pkg::SMP_W-1:0]     sample_re;
  logic signed [sbd_pkg::SMP_W-1:0]     sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface sbd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbd_pkg::ACC_W-1:0]     bin_re;
  logic signed [sbd_pkg::ACC_W-1:0]     bin_im;

  modport source (output valid, output bin_re, output bin_im, input ready);
  modport sink   (input valid, input bin_re, input bin_im, output ready);
endinterface

interface sbd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [sbd_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [sbd_pkg::CFG_DATA_W-1:0]       cfg_data;

  modport source (output valid, output cfg_index, output cfg_data, input ready);
  modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

`default_nettype wire

FILE: design/sbd_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. Only the low PH_W quotient
// bits are kept, which is the quotient modulo the table depth.
module sbd_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sbd_pkg::DIV_W-1:0]     dividend_i,
  input  logic [sbd_pkg::LEN_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [sbd_pkg::PH_W-1:0]      quot_o,
  output logic [sbd_pkg::LEN_W-1:0]     rem_o
);

  localparam int STEP_W = $clog2(sbd_pkg::DIV_W + 1);

  logic                          busy_q, busy_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [sbd_pkg::DIV_W-1:0]     dvd_q, dvd_d;
  logic [sbd_pkg::LEN_W-1:0]     dvs_q, dvs_d;
  logic [sbd_pkg::LEN_W-1:0]     rem_q, rem_d;
  logic [sbd_pkg::PH_W-1:0]      quot_q, quot_d;
  logic [sbd_pkg::LEN_W:0]       partial;
  logic [sbd_pkg::LEN_W:0]       diff;
  logic                          ge;

  assign partial = {rem_q, dvd_q[sbd_pkg::DIV_W-1]};
  assign ge      = (partial >= {1'b0, dvs_q});
  assign diff    = partial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(sbd_pkg::DIV_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[sbd_pkg::DIV_W-2:0], 1'b0};
      rem_d  = ge ? diff[sbd_pkg::LEN_W-1:0] : partial[sbd_pkg::LEN_W-1:0];
      quot_d = {quot_q[sbd_pkg::PH_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: design/sbd_ctrl.sv
`default_nettype none

module sbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbd_pkg::sbd_sts_t sts_i,
  output sbd_pkg::sbd_cmd_t cmd_o
);

  sbd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbd_pkg::ST_DIV_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sbd_pkg::ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = sbd_pkg::ST_DIV_WAIT;
      end
      sbd_pkg::ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = sbd_pkg::ST_IDLE;
        end
      end
      sbd_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_fire) begin
          state_d = sbd_pkg::ST_MUL;
        end
      end
      sbd_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = sbd_pkg::ST_ACC;
      end
      sbd_pkg::ST_ACC: begin
        if (!sts_i.acc_stall) begin
          cmd_o.acc_en = 1'b1;
          state_d      = sbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbd_pkg::ST_DIV_START;
      end
    endcase
    // A write to a known register may change the phase step, so it is worked out again.
    if (sts_i.cfg_hit) begin
      state_d = sbd_pkg::ST_DIV_START;
    end
  end

endmodule

`default_nettype wire

FILE: design/sbd_datapath.sv
`default_nettype none

module sbd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbd_pkg::sbd_cmd_t cmd_i,
  output sbd_pkg::sbd_sts_t sts_o,
  sbd_cfg_if.sink           cfg_ch_i,
  sbd_in_if.sink            in_ch_i,
  sbd_out_if.source         out_ch_o
);

  localparam int LEN_W = sbd_pkg::LEN_W;
  localparam int CNT_W = sbd_pkg::CNT_W;
  localparam int PH_W  = sbd_pkg::PH_W;
  localparam int ACC_W = sbd_pkg::ACC_W;
  localparam int SMP_W = sbd_pkg::SMP_W;
  localparam int PRD_W = sbd_pkg::PROD_W;

  // Configuration registers.
  logic [LEN_W-1:0]            frame_length_q;
  logic [sbd_pkg::BIN_W-1:0]   bin_index_q;
  logic                        real_mode_q;
  logic                        cfg_fire;
  logic                        cfg_hit;
  logic [LEN_W-1:0]            len_eff;

  // Phase step from the divider.
  logic                        div_busy;
  logic [PH_W-1:0]             q_step;
  logic [LEN_W-1:0]            r_step;

  // Frame state.
  logic [CNT_W-1:0]            count_q;
  logic [PH_W-1:0]             phase_q;
  logic [CNT_W-1:0]            rem_q;
  logic                        last_q;
  logic                        last;
  logic [LEN_W:0]              rem_sum;
  logic                        carry;
  logic [LEN_W:0]              rem_wrap;
  logic [PH_W:0]               ph_sum;
  logic [PH_W:0]               ph_wrap;

  // Sample, twiddle and product registers.
  logic signed [SMP_W-1:0]     sr_q;
  logic signed [SMP_W-1:0]     si_q;
  logic [PRD_W-1:0]            tw_q;
  logic signed [SMP_W-1:0]     wr;
  logic signed [SMP_W-1:0]     wi;
  logic signed [PRD_W-1:0]     p_rr_q;
  logic signed [PRD_W-1:0]     p_ii_q;
  logic signed [PRD_W-1:0]     p_ri_q;
  logic signed [PRD_W-1:0]     p_ir_q;
  logic signed [PRD_W:0]       pr;
  logic signed [PRD_W:0]       pi;

  // Accumulators and output register.
  logic signed [ACC_W-1:0]     acc_re_q;
  logic signed [ACC_W-1:0]     acc_im_q;
  logic signed [ACC_W-1:0]     sum_re;
  logic signed [ACC_W-1:0]     sum_im;
  logic signed [ACC_W-1:0]     out_re_q;
  logic signed [ACC_W-1:0]     out_im_q;
  logic                        out_valid_q;
  logic                        emit;
  logic                        in_fire;

  assign cfg_ch_i.ready = 1'b1;
  assign cfg_fire = cfg_ch_i.valid && cfg_ch_i.ready;
  assign cfg_hit  = cfg_fire && ((cfg_ch_i.cfg_index == sbd_pkg::REG_FRAME_LENGTH) ||
                                 (cfg_ch_i.cfg_index == sbd_pkg::REG_BIN_INDEX) ||
                                 (cfg_ch_i.cfg_index == sbd_pkg::REG_REAL_MODE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= sbd_pkg::FRAME_LENGTH_RST;
      bin_index_q    <= '0;
      real_mode_q    <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_ch_i.cfg_index)
        sbd_pkg::REG_FRAME_LENGTH: frame_length_q <= cfg_ch_i.cfg_data;
        sbd_pkg::REG_BIN_INDEX:    bin_index_q    <= cfg_ch_i.cfg_data[sbd_pkg::BIN_W-1:0];
        sbd_pkg::REG_REAL_MODE:    real_mode_q    <= cfg_ch_i.cfg_data[0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (frame_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (frame_length_q > LEN_W'(sbd_pkg::MAX_LENGTH)) begin
      len_eff = LEN_W'(sbd_pkg::MAX_LENGTH);
    end else begin
      len_eff = frame_length_q;
    end
  end

  // Phase step: bin * TW_DEPTH divided by the length, as quotient and remainder.
  sbd_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({bin_index_q, {PH_W{1'b0}}}),
    .divisor_i  (len_eff),
    .busy_o     (div_busy),
    .quot_o     (q_step),
    .rem_o      (r_step)
  );

  assign in_ch_i.ready = cmd_i.in_ready;
  assign in_fire = in_ch_i.valid && cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sr_q <= in_ch_i.sample_re;
      si_q <= real_mode_q ? '0 : in_ch_i.sample_im;
    end
  end

  // Twiddle table read, registered; the phase is stable while idle.
  always_ff @(posedge clk_i) begin
    tw_q <= sbd_pkg::TW_ROM[phase_q];
  end

  assign wr = tw_q[PRD_W-1:SMP_W];
  assign wi = tw_q[SMP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= sr_q * wr;
      p_ii_q <= si_q * wi;
      p_ri_q <= sr_q * wi;
      p_ir_q <= si_q * wr;
    end
  end

  // Phase advance: remainder then quotient, each wrapped with one subtract.
  assign last     = ({1'b0, count_q} + LEN_W'(1)) >= len_eff;
  assign rem_sum  = (LEN_W + 1)'(rem_q) + (LEN_W + 1)'(r_step);
  assign carry    = rem_sum >= (LEN_W + 1)'(len_eff);
  assign rem_wrap = carry ? (rem_sum - (LEN_W + 1)'(len_eff)) : rem_sum;
  assign ph_sum   = (PH_W + 1)'(phase_q) + (PH_W + 1)'(q_step) + (PH_W + 1)'(carry);
  assign ph_wrap  = (ph_sum >= (PH_W + 1)'(sbd_pkg::TW_DEPTH)) ?
                    (ph_sum - (PH_W + 1)'(sbd_pkg::TW_DEPTH)) : ph_sum;

  assign pr     = (PRD_W + 1)'(p_rr_q) - (PRD_W + 1)'(p_ii_q);
  assign pi     = (PRD_W + 1)'(p_ri_q) + (PRD_W + 1)'(p_ir_q);
  assign sum_re = acc_re_q + ACC_W'(pr);
  assign sum_im = acc_im_q + ACC_W'(pi);
  assign emit   = cmd_i.acc_en && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      phase_q  <= '0;
      rem_q    <= '0;
      last_q   <= 1'b0;
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (cfg_hit) begin
      count_q  <= '0;
      phase_q  <= '0;
      rem_q    <= '0;
      last_q   <= 1'b0;
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      if (cmd_i.mul_en) begin
        last_q <= last;
        if (last) begin
          count_q <= '0;
          phase_q <= '0;
          rem_q   <= '0;
        end else begin
          count_q <= count_q + CNT_W'(1);
          phase_q <= ph_wrap[PH_W-1:0];
          rem_q   <= rem_wrap[CNT_W-1:0];
        end
      end
      if (cmd_i.acc_en) begin
        if (last_q) begin
          acc_re_q <= '0;
          acc_im_q <= '0;
        end else begin
          acc_re_q <= sum_re;
          acc_im_q <= sum_im;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_re_q <= sum_re;
      out_im_q <= sum_im;
    end
  end

  assign out_ch_o.valid  = out_valid_q;
  assign out_ch_o.bin_re = out_re_q;
  assign out_ch_o.bin_im = out_im_q;

  assign sts_o.in_fire   = in_fire;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.cfg_hit   = cfg_hit;
  assign sts_o.acc_stall = last_q && out_valid_q && !out_ch_o.ready;

`ifndef ASSERT_OFF
  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rem_q} < len_eff))
    else $error("phase remainder reached the frame length");

  a_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} < len_eff))
    else $error("sample count reached the frame length");

  a_emit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("frame end did not present a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ch_o.ready))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

FILE: design/single_bin_dft_accumulator.sv
`default_nettype none

// Single-bin DFT accumulator. Each input item is one signed Q1.15 complex
// sample (the imaginary part reads as zero when real_mode is set). Sample i of
// a frame is multiplied by the twiddle cos(2*pi*n/1024) - j*sin(2*pi*n/1024),
// n = floor(1024*i*bin_index/L) mod 1024, taken from a 1024-entry Q1.15 table,
// and summed into 48-bit Q18.30 accumulators that wrap on overflow. After the
// L-th sample the two sums leave as one item and the frame starts again; L is
// frame_length, with zero read as one and values above 4096 read as 4096.
// The controller steps one sample at a time through three steps (accept,
// multiply, accumulate) and takes no new item before the last is accumulated.
// The phase step is a quotient and remainder of bin_index*1024 by L, found by
// a bit-serial divider: after reset and after each write to a known register
// index the block takes no items while it runs. Any such write also clears
// the frame without producing a result; writes to an unknown index are
// ignored. The result sits in an output register, so a waiting result holds up
// the block only when the next frame is about to end.
module single_bin_dft_accumulator (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbd_cfg_if.sink   cfg_ch_i,
  sbd_in_if.sink    in_ch_i,
  sbd_out_if.source out_ch_o
);

  sbd_pkg::sbd_cmd_t cmd;
  sbd_pkg::sbd_sts_t sts;

  sbd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sbd_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .cfg_ch_i (cfg_ch_i),
    .in_ch_i  (in_ch_i),
    .out_ch_o (out_ch_o)
  );

endmodule

`default_nettype wire
